[design/ldc_pkg.sv]
// Shared types and constants for the locker door controller.
package ldc_pkg;

    localparam int TIME_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [2:0] {
        MODE_BOOT       = 3'd0,
        MODE_AVAIL      = 3'd1,
        MODE_UNLOCKED   = 3'd2,
        MODE_DEPVERIFY  = 3'd3,
        MODE_PICKWAIT   = 3'd4,
        MODE_PICKVERIFY = 3'd5,
        MODE_ERROR      = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        CUE_NONE    = 2'd0,
        CUE_SILENCE = 2'd1,
        CUE_WARN    = 2'd2,
        CUE_TIMEOUT = 2'd3
    } cue_t;

    typedef enum logic [1:0] {
        SNAP_NONE    = 2'd0,
        SNAP_DEPOSIT = 2'd1,
        SNAP_PICKUP  = 2'd2
    } snap_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINK_TIMEOUT = 2'd0,
        REG_DOOR_TIMEOUT = 2'd1,
        REG_SNAP_GAP     = 2'd2,
        REG_RELAY_LIMIT  = 2'd3
    } reg_idx_t;

    localparam logic [TIME_W-1:0] LINK_TIMEOUT_RST = 32'd10000;
    localparam logic [TIME_W-1:0] DOOR_TIMEOUT_RST = 32'd30000;
    localparam logic [TIME_W-1:0] SNAP_GAP_RST     = 32'd5000;
    localparam logic [TIME_W-1:0] RELAY_LIMIT_RST  = 32'd5000;

    typedef struct packed {
        logic [TIME_W-1:0] link_timeout_ms;
        logic [TIME_W-1:0] door_timeout_ms;
        logic [TIME_W-1:0] snapshot_gap_ms;
        logic [TIME_W-1:0] relay_limit_ms;
    } cfg_t;

    typedef struct packed {
        logic              door_shut;
        logic              beam_broken;
        logic              card_seen;
        logic              button_pressed;
        logic              link_connected;
        logic              link_ready;
        logic [TIME_W-1:0] now_ms;
    } in_item_t;

    typedef struct packed {
        cue_t  buzzer_cue;
        snap_t snapshot_kind;
        logic  relay_on;
        mode_t box_mode;
    } out_item_t;

    typedef struct packed {
        mode_t             mode;
        logic [TIME_W-1:0] mode_entry_time;
        logic              relay;
        logic [TIME_W-1:0] relay_start_time;
        logic [TIME_W-1:0] last_beam_time;
        logic [TIME_W-1:0] last_snap_time;
    } ctx_t;

endpackage

[design/locker_door_controller.sv]
// Top level of the locker door controller: streams, config registers, state.
//
// Usage:
//   Each item on the s_ stream is one polling step: a millisecond timestamp
//   and the sampled link, button, card, IR beam and door flags. Each step
//   yields exactly one item on the m_ stream carrying the state after the
//   step, the relay level, a snapshot request and a buzzer cue.
//   Configuration: cfg_valid/cfg_ready with cfg_index (0 link timeout,
//   1 door timeout, 2 snapshot gap, 3 relay limit) and cfg_data. cfg_ready
//   is always high; write only while no step is in flight.
//   An accepted item sits in the input register while the step logic runs;
//   the result register loads once the result slot is free, and the result
//   is then offered on m_.
//   Throughput: one item per clock while m_ does not stall. The step logic is
//   a single pass of 32-bit subtract/compare units between the input register
//   and the result register; the controller state updates at the same edge the
//   result loads, so the next item always sees the updated state.
//   Stall: when a result waits and m_tready is low, the result is held and
//   the input register keeps any item; s_tready then drops until the result is taken.
//   Reset (rst_n low, async): state returns to boot, relay open, all time
//   stamps zero, registers to their defaults, both stages empty.
module locker_door_controller
    import ldc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [TIME_W-1:0]      cfg_data,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [31:0] now_ms, [32] link_ready, [33] link_connected, [34] button_pressed,
    // [35] card_seen, [36] beam_broken, [37] door_shut, [39:38] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [2:0] box_mode, [3] relay_on, [5:4] snapshot_kind, [7:6] buzzer_cue
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    cfg_t      cfg_reg;
    ctx_t      ctx_reg;
    ctx_t      ctx_next;
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      advance;

    // step moves from input register to result register when the result slot frees up
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_item_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_timeout_ms <= LINK_TIMEOUT_RST;
            cfg_reg.door_timeout_ms <= DOOR_TIMEOUT_RST;
            cfg_reg.snapshot_gap_ms <= SNAP_GAP_RST;
            cfg_reg.relay_limit_ms  <= RELAY_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_LINK_TIMEOUT: cfg_reg.link_timeout_ms <= cfg_data;
                REG_DOOR_TIMEOUT: cfg_reg.door_timeout_ms <= cfg_data;
                REG_SNAP_GAP:     cfg_reg.snapshot_gap_ms <= cfg_data;
                REG_RELAY_LIMIT:  cfg_reg.relay_limit_ms  <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
        end
    end

    ldc_step u_step (
        .cfg  (cfg_reg),
        .cur  (ctx_reg),
        .item (in_item_reg),
        .nxt  (ctx_next),
        .res  (out_item_next)
    );

    // controller state, updated once per step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg.mode             <= MODE_BOOT;
            ctx_reg.mode_entry_time  <= '0;
            ctx_reg.relay            <= 1'b0;
            ctx_reg.relay_start_time <= '0;
            ctx_reg.last_beam_time   <= '0;
            ctx_reg.last_snap_time   <= '0;
        end
        else if (advance)
        begin
            ctx_reg <= ctx_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

[design/ldc_step.sv]
// Next-state and result logic for one polling step.
module ldc_step
    import ldc_pkg::*;
(
    input  cfg_t      cfg,
    input  ctx_t      cur,
    input  in_item_t  item,
    output ctx_t      nxt,
    output out_item_t res
);

    logic [TIME_W-1:0] since_entry;
    logic [TIME_W-1:0] since_beam;
    logic [TIME_W-1:0] since_snap;
    logic [TIME_W-1:0] since_relay;
    ctx_t              st;
    cue_t              cue;
    snap_t             snap;

    assign since_entry = item.now_ms - cur.mode_entry_time;
    assign since_beam  = item.now_ms - cur.last_beam_time;
    assign since_snap  = item.now_ms - cur.last_snap_time;

    always_comb
    begin
        st   = cur;
        cue  = CUE_NONE;
        snap = SNAP_NONE;
        unique case (cur.mode)
            MODE_BOOT:
            begin
                if (item.link_ready)
                begin
                    st.mode = MODE_AVAIL;
                    st.mode_entry_time = item.now_ms;
                    cue = CUE_SILENCE;
                end
                else if (since_entry > cfg.link_timeout_ms)
                begin
                    st.mode = MODE_ERROR;
                    st.mode_entry_time = item.now_ms;
                    cue = CUE_TIMEOUT;
                end
            end
            MODE_AVAIL:
            begin
                if (item.button_pressed)
                begin
                    st.relay = 1'b1;
                    st.relay_start_time = item.now_ms;
                    st.mode = MODE_UNLOCKED;
                    st.mode_entry_time = item.now_ms;
                    cue = CUE_WARN;
                end
                else if (item.card_seen)
                begin
                    st.relay = 1'b1;
                    st.relay_start_time = item.now_ms;
                    st.mode = MODE_PICKWAIT;
                    st.mode_entry_time = item.now_ms;
                end
                else if (item.beam_broken && (since_beam > cfg.snapshot_gap_ms))
                begin
                    st.last_beam_time = item.now_ms;
                    st.mode = MODE_DEPVERIFY;
                    st.mode_entry_time = item.now_ms;
                end
            end
            MODE_UNLOCKED, MODE_PICKWAIT:
            begin
                if (since_entry > cfg.door_timeout_ms)
                begin
                    st.mode = MODE_ERROR;
                    st.mode_entry_time = item.now_ms;
                    cue = CUE_TIMEOUT;
                end
                else if (item.door_shut)
                begin
                    st.mode = (cur.mode == MODE_UNLOCKED) ? MODE_DEPVERIFY : MODE_PICKVERIFY;
                    st.mode_entry_time = item.now_ms;
                end
            end
            MODE_DEPVERIFY, MODE_PICKVERIFY:
            begin
                if (since_snap >= cfg.snapshot_gap_ms)
                begin
                    st.last_snap_time = item.now_ms;
                    snap = (cur.mode == MODE_DEPVERIFY) ? SNAP_DEPOSIT : SNAP_PICKUP;
                end
                st.mode = MODE_AVAIL;
                st.mode_entry_time = item.now_ms;
                cue = CUE_SILENCE;
            end
            MODE_ERROR:
            begin
                if (item.door_shut && item.link_connected)
                begin
                    st.mode = MODE_AVAIL;
                    st.mode_entry_time = item.now_ms;
                    cue = CUE_SILENCE;
                end
            end
            default:
            begin
                st = cur;
            end
        endcase
    end

    // relay safety check runs after the state step, including the closing step
    assign since_relay = item.now_ms - st.relay_start_time;

    always_comb
    begin
        nxt = st;
        if (st.relay && (since_relay > cfg.relay_limit_ms))
        begin
            nxt.relay = 1'b0;
        end
        res.box_mode      = nxt.mode;
        res.relay_on      = nxt.relay;
        res.snapshot_kind = snap;
        res.buzzer_cue    = cue;
    end

endmodule
